// ===== sv/ctcgc_pkg.sv =====
// ----------------------------------------------------------------------------
// ctcgc_pkg
// Shared types and constants of the CTC greedy collapse block.
// ----------------------------------------------------------------------------
`default_nettype none

package ctcgc_pkg;

    localparam int CLASS_W   = 16;
    localparam int SCORE_W   = 16;
    localparam int CHARS_W   = 13;
    localparam int ROWLEN_W  = 13;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [SCORE_W-1:0] SCORE_ONE = 16'h8000;

    localparam int MAX_ROW_STEPS_DEF = 4096;
    localparam int CLASS_BITS_DEF    = 16;

    // entries of the queue between classifier and result side
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLANK_CLASS    = 2'd0,
        CFG_DICT_SIZE      = 2'd1,
        CFG_ROW_LENGTH     = 2'd2,
        CFG_SCORES_PRESENT = 2'd3
    } t_cfg_index;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_SUM
    } t_back_state;

    typedef enum logic {
        KIND_CHAR    = 1'b0,
        KIND_SUMMARY = 1'b1
    } t_kind;

    typedef struct packed {
        logic [CLASS_W-1:0] step_class;
        logic [SCORE_W-1:0] step_score;
    } t_in_item;

    typedef struct packed {
        logic               kind;
        logic [CLASS_W-1:0] char_class;
        logic [SCORE_W-1:0] char_score;
        logic               known_char;
        logic [CHARS_W-1:0] row_chars;
        logic [SCORE_W-1:0] row_mean_score;
        logic               run_last;
    } t_out_item;

    // classified step handed from front to back
    typedef struct packed {
        logic               emit;
        logic               row_end;
        logic [CLASS_W-1:0] cls;
        logic [SCORE_W-1:0] score;
        logic               known;
    } t_job;

endpackage

`default_nettype wire

// ===== sv/ctc_greedy_collapse_top.sv =====
// ----------------------------------------------------------------------------
// ctc_greedy_collapse_top
// CTC greedy collapse of an argmax stream into characters and row summaries.
// ----------------------------------------------------------------------------
// The front takes one time step per cycle and pushes every step that emits a
// character or ends a row into a four-entry job queue; dropped steps are not
// queued. The back turns each job into at most two words: a character word
// lands in the output register at the edge that pops the job, and at a row
// end a summary word follows once a bit-serial divider has formed the row
// mean; the back takes no new job while it divides. The input runs at one
// step per cycle while the queue has room and stalls once it is full.
`default_nettype none

module ctc_greedy_collapse_top import ctcgc_pkg::*; #(
    parameter int MAX_ROW_STEPS = MAX_ROW_STEPS_DEF,
    parameter int CLASS_BITS    = CLASS_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire t_in_item              i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output t_out_item                  o_out_data
);

    logic w_push;
    logic w_full;
    logic w_pop;
    logic w_empty;
    t_job w_push_job;
    t_job w_head_job;

    ctcgc_front #(
        .MAX_ROW_STEPS (MAX_ROW_STEPS),
        .CLASS_BITS    (CLASS_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .i_q_full    (w_full),
        .o_q_push    (w_push),
        .o_q_job     (w_push_job)
    );

    ctcgc_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_job),
        .o_full      (w_full),
        .i_pop       (w_pop),
        .o_head      (w_head_job),
        .o_empty     (w_empty)
    );

    ctcgc_back #(
        .MAX_ROW_STEPS (MAX_ROW_STEPS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (w_empty),
        .i_q_job     (w_head_job),
        .o_q_pop     (w_pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // a job is never offered to a full queue
    a_no_push_when_full: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_full)
    ) else $error("job pushed into full queue");

    // the back never pops an empty queue
    a_no_pop_when_empty: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !(w_pop && w_empty)
    ) else $error("job popped from empty queue");

    // a summary always closes the step's results and its mean stays within one
    a_summary_fields: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.kind) |->
            (o_out_data.run_last && (o_out_data.row_mean_score <= SCORE_ONE))
    ) else $error("bad summary word");

    // character words carry no row totals
    a_char_fields: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.kind) |->
            ((o_out_data.row_chars == '0) && (o_out_data.row_mean_score == '0))
    ) else $error("character word carries row totals");

endmodule

`default_nettype wire

// ===== sv/ctcgc_front.sv =====
// ----------------------------------------------------------------------------
// ctcgc_front
// Accepts time steps, holds the configuration and classifies each step as
// dropped, emitted character and/or row end.
// ----------------------------------------------------------------------------
`default_nettype none

module ctcgc_front import ctcgc_pkg::*; #(
    parameter int MAX_ROW_STEPS = MAX_ROW_STEPS_DEF,
    parameter int CLASS_BITS    = CLASS_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    input  wire t_in_item              i_in_data,
    output logic                       o_in_stall,
    input  wire logic                  i_q_full,
    output logic                       o_q_push,
    output t_job                       o_q_job
);

    localparam int PW = $clog2(MAX_ROW_STEPS + 1);
    localparam int LW = (PW > ROWLEN_W) ? PW : ROWLEN_W;
    localparam int CM = (CLASS_BITS < CLASS_W) ? CLASS_BITS : CLASS_W;
    localparam logic [CLASS_W:0] MASK_FULL =
        ((CLASS_W+1)'(1) << CM) - (CLASS_W+1)'(1);
    localparam logic [CLASS_W-1:0] CLASS_MASK = MASK_FULL[CLASS_W-1:0];

    logic [CLASS_W-1:0]  r_blank_class;
    logic [CLASS_W-1:0]  r_dict_size;
    logic [ROWLEN_W-1:0] r_row_length;
    logic                r_scores_present;

    logic [CLASS_W-1:0]  r_prior_class;
    logic                r_prior_valid;
    logic [PW-1:0]       r_pos;

    logic [CLASS_W-1:0]  w_cls;
    logic [CLASS_W-1:0]  w_blank;
    logic [SCORE_W-1:0]  w_score;
    logic [LW-1:0]       w_len;
    logic [LW-1:0]       w_pos_inc;
    logic                w_row_end;
    logic                w_emit;
    logic                w_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blank_class    <= '0;
            r_dict_size      <= '0;
            r_row_length     <= ROWLEN_W'(1);
            r_scores_present <= 1'b1;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_BLANK_CLASS:    r_blank_class    <= i_cfg_data[CLASS_W-1:0];
                CFG_DICT_SIZE:      r_dict_size      <= i_cfg_data[CLASS_W-1:0];
                CFG_ROW_LENGTH:     r_row_length     <= i_cfg_data[ROWLEN_W-1:0];
                CFG_SCORES_PRESENT: r_scores_present <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_cls   = i_in_data.step_class & CLASS_MASK;
        w_blank = r_blank_class & CLASS_MASK;

        if (!r_scores_present || (i_in_data.step_score > SCORE_ONE)) begin
            w_score = SCORE_ONE;
        end else begin
            w_score = i_in_data.step_score;
        end

        // zero means one step, above the maximum saturates
        if (r_row_length == '0) begin
            w_len = LW'(1);
        end else if (LW'(r_row_length) > LW'(MAX_ROW_STEPS)) begin
            w_len = LW'(MAX_ROW_STEPS);
        end else begin
            w_len = LW'(r_row_length);
        end

        w_pos_inc = LW'(r_pos) + LW'(1);
        w_row_end = (w_pos_inc >= w_len);
        w_emit    = !(r_prior_valid && (w_cls == r_prior_class)) && (w_cls != w_blank);
        w_accept  = i_in_valid && !i_q_full;

        o_in_stall    = i_q_full;
        o_q_push      = w_accept && (w_emit || w_row_end);
        o_q_job.emit    = w_emit;
        o_q_job.row_end = w_row_end;
        o_q_job.cls     = w_cls;
        o_q_job.score   = w_score;
        o_q_job.known   = (w_cls < r_dict_size);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prior_class <= '0;
            r_prior_valid <= 1'b0;
            r_pos         <= '0;
        end else if (w_accept) begin
            if (w_row_end) begin
                r_prior_class <= '0;
                r_prior_valid <= 1'b0;
                r_pos         <= '0;
            end else begin
                // blank steps still become the previous class
                r_prior_class <= w_cls;
                r_prior_valid <= 1'b1;
                r_pos         <= w_pos_inc[PW-1:0];
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/ctcgc_fifo.sv =====
// ----------------------------------------------------------------------------
// ctcgc_fifo
// Short job queue between the classifier and the result side.
// ----------------------------------------------------------------------------
`default_nettype none

module ctcgc_fifo import ctcgc_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_push_data,
    output logic      o_full,
    input  wire logic i_pop,
    output t_job      o_head,
    output logic      o_empty
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_job          r_mem [QUEUE_DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    logic          w_push;
    logic          w_pop;

    assign o_full  = (r_count == CW'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CW'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/ctcgc_back.sv =====
// ----------------------------------------------------------------------------
// ctcgc_back
// Carries out queued jobs: row totals, character results, and the row mean
// through a bit-serial restoring divider, into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ctcgc_back import ctcgc_pkg::*; #(
    parameter int MAX_ROW_STEPS = MAX_ROW_STEPS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_q_empty,
    input  wire t_job i_q_job,
    output logic      o_q_pop,
    input  wire logic i_out_stall,
    output logic      o_out_valid,
    output t_out_item o_out_data
);

    localparam int PW  = $clog2(MAX_ROW_STEPS + 1);
    localparam int TW  = PW + SCORE_W - 1;
    localparam int DCW = $clog2(TW);

    t_back_state    r_state, n_state;
    logic           r_out_valid, n_out_valid;
    t_out_item      r_out, n_out;
    logic [TW-1:0]  r_tot, n_tot;
    logic [PW-1:0]  r_cnt, n_cnt;
    logic [TW-1:0]  r_div_quo, n_div_quo;
    logic [PW-1:0]  r_div_rem, n_div_rem;
    logic [PW-1:0]  r_div_den, n_div_den;
    logic [DCW-1:0] r_div_step, n_div_step;

    logic           w_out_free;
    logic [TW-1:0]  w_row_tot;
    logic [PW-1:0]  w_row_cnt;
    logic [PW:0]    w_rem_sh;
    logic [PW:0]    w_rem_sub;
    logic           w_ge;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
            r_tot       <= '0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_tot       <= n_tot;
            r_cnt       <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out      <= n_out;
        r_div_quo  <= n_div_quo;
        r_div_rem  <= n_div_rem;
        r_div_den  <= n_div_den;
        r_div_step <= n_div_step;
    end

    always_comb begin
        w_out_free = !r_out_valid || !i_out_stall;
        w_row_tot  = r_tot + (i_q_job.emit ? TW'(i_q_job.score) : '0);
        w_row_cnt  = r_cnt + (i_q_job.emit ? PW'(1) : '0);

        // one quotient bit per cycle
        w_rem_sh  = {r_div_rem, r_div_quo[TW-1]};
        w_ge      = (w_rem_sh >= {1'b0, r_div_den});
        w_rem_sub = w_rem_sh - {1'b0, r_div_den};

        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        n_tot       = r_tot;
        n_cnt       = r_cnt;
        n_div_quo   = r_div_quo;
        n_div_rem   = r_div_rem;
        n_div_den   = r_div_den;
        n_div_step  = r_div_step;
        o_q_pop     = 1'b0;

        case (r_state)
            BK_IDLE: begin
                if (!i_q_empty && w_out_free) begin
                    o_q_pop = 1'b1;
                    if (i_q_job.emit) begin
                        n_out_valid         = 1'b1;
                        n_out.kind          = KIND_CHAR;
                        n_out.char_class    = i_q_job.cls;
                        n_out.char_score    = i_q_job.score;
                        n_out.known_char    = i_q_job.known;
                        n_out.row_chars     = '0;
                        n_out.row_mean_score = '0;
                        n_out.run_last      = !i_q_job.row_end;
                    end
                    if (i_q_job.row_end) begin
                        n_tot      = '0;
                        n_cnt      = '0;
                        n_div_quo  = w_row_tot;
                        n_div_den  = w_row_cnt;
                        n_div_rem  = '0;
                        n_div_step = DCW'(TW - 1);
                        n_state    = BK_DIV;
                    end else begin
                        n_tot = w_row_tot;
                        n_cnt = w_row_cnt;
                    end
                end
            end
            BK_DIV: begin
                n_div_rem  = w_ge ? w_rem_sub[PW-1:0] : w_rem_sh[PW-1:0];
                n_div_quo  = {r_div_quo[TW-2:0], w_ge};
                n_div_step = r_div_step - DCW'(1);
                if (r_div_step == '0) begin
                    n_state = BK_SUM;
                end
            end
            BK_SUM: begin
                if (w_out_free) begin
                    n_out_valid          = 1'b1;
                    n_out.kind           = KIND_SUMMARY;
                    n_out.char_class     = '0;
                    n_out.char_score     = '0;
                    n_out.known_char     = 1'b0;
                    n_out.row_chars      = CHARS_W'(r_div_den);
                    n_out.row_mean_score = (r_div_den == '0) ? '0 : r_div_quo[SCORE_W-1:0];
                    n_out.run_last       = 1'b1;
                    n_state              = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the CTC greedy collapse block word by word against a behavioral
// predictor: directed steps for the collapse and row rules, then random rows
// under several register settings, with random idling on both sides and a
// long output hold-off that backs the block up.
// ----------------------------------------------------------------------------

module testbench;
    import ctcgc_pkg::*;

    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN_WAIT = 40;
    localparam int MAX_STEPS  = MAX_ROW_STEPS_DEF;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    t_cfg_index            cfg_index = CFG_BLANK_CLASS;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    t_in_item              in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_item             out_data;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_request   = 0;
    int bad_words      = 0;
    int quiet_cycles   = 0;

    // register copies and row state of the predictor
    logic [15:0] reg_blank     = 16'd0;
    logic [15:0] reg_dict      = 16'd0;
    logic [12:0] reg_row_len   = 13'd1;
    logic        reg_scores_on = 1'b1;
    logic [15:0] last_cls      = 16'd0;
    logic        last_seen     = 1'b0;
    int unsigned step_pos      = 0;
    int unsigned score_sum     = 0;
    int unsigned char_cnt      = 0;

    t_out_item decoded_q[$];

    ctc_greedy_collapse_top i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    // works out the words one time step causes
    task automatic decode_step(input t_in_item w);
        logic [15:0] cls;
        logic [15:0] score;
        int unsigned len;
        bit          row_end;
        bit          emit;
        t_out_item   r;
        cls   = w.step_class;
        score = (w.step_score > SCORE_ONE) ? SCORE_ONE : w.step_score;
        if (!reg_scores_on) begin
            score = SCORE_ONE;
        end
        len = (reg_row_len == 0) ? 1 : reg_row_len;
        if (len > MAX_STEPS) begin
            len = MAX_STEPS;
        end
        row_end   = (step_pos + 1) >= len;
        emit      = !(last_seen && cls == last_cls) && cls != reg_blank;
        last_cls  = cls;
        last_seen = 1'b1;
        if (emit) begin
            score_sum += score;
            char_cnt  += 1;
            r            = '0;
            r.kind       = KIND_CHAR;
            r.char_class = cls;
            r.char_score = score;
            r.known_char = cls < reg_dict;
            r.run_last   = !row_end;
            decoded_q = {decoded_q, r};
        end
        if (row_end) begin
            r                = '0;
            r.kind           = KIND_SUMMARY;
            r.row_chars      = char_cnt[CHARS_W-1:0];
            r.row_mean_score = (char_cnt == 0) ? 16'd0 : 16'(score_sum / char_cnt);
            r.run_last       = 1'b1;
            decoded_q = {decoded_q, r};
            last_cls  = 16'd0;
            last_seen = 1'b0;
            step_pos  = 0;
            score_sum = 0;
            char_cnt  = 0;
        end else begin
            step_pos += 1;
        end
    endtask

    function automatic string word_text(input t_out_item w);
        return $sformatf("kind=%0d class=%0d score=%0d known=%0d chars=%0d mean=%0d last=%0d",
                         w.kind, w.char_class, w.char_score, w.known_char,
                         w.row_chars, w.row_mean_score, w.run_last);
    endfunction

    task automatic compare_word(input t_out_item got);
        t_out_item want;
        if (decoded_q.size() == 0) begin
            if (bad_words < 10) begin
                $display("unexpected word: %s", word_text(got));
            end
            bad_words++;
        end else begin
            want = decoded_q.pop_front();
            if (got.kind !== want.kind || got.char_class !== want.char_class ||
                got.char_score !== want.char_score || got.known_char !== want.known_char ||
                got.row_chars !== want.row_chars ||
                got.row_mean_score !== want.row_mean_score ||
                got.run_last !== want.run_last) begin
                if (bad_words < 10) begin
                    $display("word mismatch: expected %s", word_text(want));
                    $display("               actual   %s", word_text(got));
                end
                bad_words++;
            end
        end
    endtask

    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                compare_word(out_data);
            end
            if (in_valid && !in_stall) begin
                decode_step(in_data);
            end
            if (cfg_we) begin
                case (cfg_index)
                    CFG_BLANK_CLASS:    reg_blank     = cfg_data;
                    CFG_DICT_SIZE:      reg_dict      = cfg_data;
                    CFG_ROW_LENGTH:     reg_row_len   = cfg_data[ROWLEN_W-1:0];
                    CFG_SCORES_PRESENT: reg_scores_on = cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // output side: random stalls, or a counted hold-off when one is requested
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge clk);
            if (hold_left == 0 && hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    task automatic push_step(input logic [15:0] cls, input logic [15:0] score);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid           <= 1'b1;
        in_data.step_class <= cls;
        in_data.step_score <= score;
        do @(posedge clk); while (in_stall);
    endtask

    // input quiet until every word is out, then room for dropped steps in flight
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic set_regs(input logic [15:0] blank, input logic [15:0] dict,
                            input logic [15:0] row_len, input logic scores);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_BLANK_CLASS;
        cfg_data  <= blank;
        @(negedge clk);
        cfg_index <= CFG_DICT_SIZE;
        cfg_data  <= dict;
        @(negedge clk);
        cfg_index <= CFG_ROW_LENGTH;
        cfg_data  <= row_len;
        @(negedge clk);
        cfg_index <= CFG_SCORES_PRESENT;
        cfg_data  <= {15'($urandom), scores};
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // reset registers: one-step rows, blank 0, empty dictionary
    task automatic test_reset_defaults();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        push_step(16'd0, 16'd100);
        push_step(16'd5, 16'hFFFF);
        push_step(16'd5, 16'd200);
        settle();
    endtask

    task automatic test_collapse_rules();
        set_regs(16'hFFFF, 16'd10, 16'd8, 1'b1);
        push_step(16'd9, SCORE_ONE);
        push_step(16'd9, 16'd1000);
        push_step(16'd10, 16'd0);
        // blank in between lets the same class through again
        push_step(16'hFFFF, 16'd5);
        push_step(16'd10, 16'd7);
        push_step(16'd10, 16'd8);
        push_step(16'd0, 16'd32767);
        push_step(16'hFFFF, 16'd0);
        settle();
    endtask

    task automatic test_row_length_edges();
        // zero length acts as one, scores replaced by one
        set_regs(16'd0, 16'hFFFF, 16'h2000, 1'b0);
        push_step(16'd1, 16'd123);
        settle();
        // oversized length saturates, then gets cut short mid-row
        set_regs(16'd0, 16'hFFFF, 16'hFFFF, 1'b1);
        push_step(16'd1, 16'd1);
        push_step(16'd2, 16'd2);
        push_step(16'd1, 16'd3);
        push_step(16'd3, SCORE_ONE);
        settle();
        set_regs(16'd0, 16'hFFFF, 16'd2, 1'b1);
        push_step(16'd4, 16'd100);
        settle();
    endtask

    task automatic test_random_rows(input int idle_pct, input int stall_pct);
        logic [15:0] blank;
        logic [15:0] dict;
        logic [15:0] row_len;
        logic [15:0] cls;
        logic [15:0] score;
        logic [15:0] prev;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int c = 0; c < 6; c++) begin
            case ($urandom_range(3))
                0:       blank = 16'd0;
                1:       blank = 16'hFFFF;
                2:       blank = 16'($urandom_range(7));
                default: blank = 16'($urandom);
            endcase
            case ($urandom_range(3))
                0:       dict = 16'd0;
                1:       dict = 16'hFFFF;
                2:       dict = 16'($urandom_range(1, 8));
                default: dict = 16'($urandom);
            endcase
            case ($urandom_range(9))
                0:       row_len = 16'd1;
                1:       row_len = {3'($urandom), 13'($urandom_range(1, 6))};
                2:       row_len = 16'd0;
                3:       row_len = 16'($urandom_range(50, 150));
                default: row_len = 16'($urandom_range(2, 16));
            endcase
            set_regs(blank, dict, row_len, 1'($urandom_range(1)));
            prev = blank;
            for (int i = 0; i < 60; i++) begin
                // small alphabet so repeats and blanks show up often
                case ($urandom_range(19))
                    0, 1, 2, 3, 4, 5: cls = blank;
                    6, 7, 8:          cls = prev;
                    9:                cls = dict;
                    10:               cls = dict - 16'd1;
                    18, 19:           cls = 16'($urandom);
                    default:          cls = 16'($urandom_range(7));
                endcase
                case ($urandom_range(19))
                    0:       score = 16'd0;
                    1, 2:    score = SCORE_ONE;
                    3:       score = 16'($urandom_range(32769, 65535));
                    default: score = 16'($urandom_range(32768));
                endcase
                push_step(cls, score);
                prev = cls;
            end
            settle();
        end
    endtask

    // output held off while steps keep coming, short rows keep the divider busy
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_regs(16'd0, 16'd4, 16'd3, 1'b1);
        hold_request = 300;
        for (int i = 0; i < 150; i++) begin
            push_step(16'($urandom_range(1, 6)), 16'($urandom_range(32768)));
        end
        settle();
    endtask

    initial begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_collapse_rules();
        test_row_length_edges();
        test_random_rows(0, 0);
        test_backpressure();
        test_random_rows(48, 0);
        test_random_rows(0, 48);
        test_random_rows(35, 35);
        settle();
        if (bad_words == 0 && decoded_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
